// ===== rtl/core/cdll_pkg.sv =====
// Shared types and constants for the circular doubly linked list block.
package cdll_pkg;

    localparam int VALUE_W     = 32;
    localparam int POS_W       = 8;
    localparam int MAX_RESULTS = 32;
    localparam int EMIT_W      = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        CMD_INS_FRONT = 3'd0,
        CMD_INS_BACK  = 3'd1,
        CMD_INS_AT    = 3'd2,
        CMD_DEL_FRONT = 3'd3,
        CMD_DEL_BACK  = 3'd4,
        CMD_DEL_AT    = 3'd5,
        CMD_SHOW_FWD  = 3'd6,
        CMD_SHOW_BACK = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd                       command;
        logic signed [VALUE_W-1:0]  value;
        logic        [POS_W-1:0]    position;
    } t_in_item;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  element;
        t_status                    status;
        logic                       last;
    } t_out_item;

    typedef struct packed {
        logic                       valid;
        logic signed [VALUE_W-1:0]  value;
    } t_cell;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE,
        CELL_ROT_LEFT,
        CELL_ROT_RIGHT
    } t_cell_op;

    typedef struct packed {
        t_cell_op                   op;
        logic        [POS_W-1:0]    pos_idx;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctrl;

    typedef enum logic {
        ST_IDLE,
        ST_SHOW
    } t_state;

endpackage

// ===== rtl/core/cdll_cell.sv =====
// One storage cell of the list chain: holds the element at its own position.
module cdll_cell #(
    parameter int INDEX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cdll_pkg::t_cell_ctrl i_ctrl,
    input  cdll_pkg::t_cell     i_left,
    input  cdll_pkg::t_cell     i_right,
    output cdll_pkg::t_cell     o_cell
);

    localparam logic [cdll_pkg::POS_W-1:0] IDX = cdll_pkg::POS_W'(INDEX);

    logic                                r_valid;
    logic signed [cdll_pkg::VALUE_W-1:0] r_value;
    cdll_pkg::t_cell                     n_cell;

    always_comb begin
        n_cell.valid = r_valid;
        n_cell.value = r_value;
        case (i_ctrl.op)
            cdll_pkg::CELL_INSERT: begin
                if (IDX == i_ctrl.pos_idx) begin
                    n_cell.valid = 1'b1;
                    n_cell.value = i_ctrl.value;
                end else if (IDX > i_ctrl.pos_idx) begin
                    n_cell = i_left;    // make room: move one place back
                end
            end
            cdll_pkg::CELL_DELETE: begin
                if (IDX >= i_ctrl.pos_idx) begin
                    n_cell = i_right;   // close the gap
                end
            end
            cdll_pkg::CELL_ROT_LEFT:  n_cell = i_right;
            cdll_pkg::CELL_ROT_RIGHT: n_cell = i_left;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_cell.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_cell.value;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.value = r_value;

endmodule

// ===== rtl/core/circular_doubly_linked_list.sv =====
// Top level of the circular doubly linked list: command decode, cell chain and result register.
//
// The list is held in order in a row of CAPACITY cells: cell 0 holds the front element, cell
// count-1 the back, and the cells beyond hold nothing. Insert and delete commands (front, back
// or a 1-based position) move every cell past the affected place one step along the chain at
// once, so they finish in the cycle the command transfer happens and their single result is
// in the output register in the cycle after. Show commands turn the whole ring of cells round
// once, one step per cycle unless the result side stalls: forward turns it towards cell 0 and
// reads cell 0, backward turns it the other way and reads cell CAPACITY-1. A show therefore
// makes CAPACITY steps, after which the list sits where it started; at most 32 elements are
// reported, the last carrying the last flag. A show of an empty list gives one
// result with status empty. While a show runs no new command is taken; otherwise a command is
// taken whenever the output register is free or being emptied in the same cycle. A bad
// position gives status invalid, an insert into a full list status full, a delete from an
// empty list status empty, and none of these changes the list.
module circular_doubly_linked_list #(
    parameter int CAPACITY = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  cdll_pkg::t_in_item   i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output cdll_pkg::t_out_item  o_out
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int STEP_W = $clog2(CAPACITY);
    localparam int POS_W  = cdll_pkg::POS_W;
    localparam int EMIT_W = cdll_pkg::EMIT_W;

    // ---------------------------------------------------------------
    // Control registers
    // ---------------------------------------------------------------
    cdll_pkg::t_state     r_state, n_state;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [EMIT_W-1:0]    r_emit, n_emit;
    logic                 r_dir_back, n_dir_back;
    logic                 r_out_valid, n_out_valid;
    cdll_pkg::t_out_item  r_out, n_out;

    // ---------------------------------------------------------------
    // Cell chain
    // ---------------------------------------------------------------
    cdll_pkg::t_cell_ctrl cell_ctrl;
    cdll_pkg::t_cell      cell_q     [CAPACITY];
    cdll_pkg::t_cell      cell_left  [CAPACITY];
    cdll_pkg::t_cell      cell_right [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        // left neighbour wraps round the ring (only rotate-right uses the wrap)
        assign cell_left[g] = cell_q[(g + CAPACITY - 1) % CAPACITY];

        if (g == CAPACITY - 1) begin : g_tail
            // past the end of the row: a delete pulls in an empty cell,
            // a left rotation pulls in the front
            always_comb begin
                if (cell_ctrl.op == cdll_pkg::CELL_ROT_LEFT) begin
                    cell_right[g] = cell_q[0];
                end else begin
                    cell_right[g] = '0;
                end
            end
        end else begin : g_body
            assign cell_right[g] = cell_q[g + 1];
        end

        cdll_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (cell_ctrl),
            .i_left  (cell_left[g]),
            .i_right (cell_right[g]),
            .o_cell  (cell_q[g])
        );
    end

    // ---------------------------------------------------------------
    // Decode helpers
    // ---------------------------------------------------------------
    logic                 out_free;
    logic                 accept;
    logic                 show_start;
    logic                 step_adv;
    logic                 emit;
    logic                 last_step;
    logic [POS_W-1:0]     count_p;
    logic [POS_W-1:0]     ins_pos;
    logic [POS_W-1:0]     del_pos;
    logic [POS_W-1:0]     limit;
    cdll_pkg::t_cell      tap;

    assign out_free  = !r_out_valid || i_out_ready;
    assign count_p   = POS_W'(r_count);
    assign last_step = (r_step == STEP_W'(CAPACITY - 1));
    assign tap       = r_dir_back ? cell_q[CAPACITY-1] : cell_q[0];

    // number of results a show reports
    assign limit = (count_p < POS_W'(cdll_pkg::MAX_RESULTS)) ? count_p
                                                             : POS_W'(cdll_pkg::MAX_RESULTS);

    always_comb begin
        case (i_in.command)
            cdll_pkg::CMD_INS_FRONT: ins_pos = POS_W'(1);
            cdll_pkg::CMD_INS_BACK:  ins_pos = count_p + POS_W'(1);
            default:                 ins_pos = i_in.position;
        endcase
        case (i_in.command)
            cdll_pkg::CMD_DEL_FRONT: del_pos = POS_W'(1);
            cdll_pkg::CMD_DEL_BACK:  del_pos = count_p;
            default:                 del_pos = i_in.position;
        endcase
    end

    // ---------------------------------------------------------------
    // Outputs and datapath control
    // ---------------------------------------------------------------
    always_comb begin
        o_in_ready      = (r_state == cdll_pkg::ST_IDLE) && out_free;
        accept          = i_in_valid && o_in_ready;
        show_start      = 1'b0;
        step_adv        = 1'b0;
        emit            = 1'b0;
        cell_ctrl.op    = cdll_pkg::CELL_HOLD;
        cell_ctrl.pos_idx = '0;
        cell_ctrl.value = i_in.value;
        n_count         = r_count;
        n_step          = r_step;
        n_emit          = r_emit;
        n_dir_back      = r_dir_back;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_out           = r_out;

        case (r_state)
            cdll_pkg::ST_IDLE: begin
                if (accept) begin
                    n_out.element = '0;
                    n_out.status  = cdll_pkg::STAT_OK;
                    n_out.last    = 1'b1;
                    n_out_valid   = 1'b1;
                    case (i_in.command)
                        cdll_pkg::CMD_INS_FRONT,
                        cdll_pkg::CMD_INS_BACK,
                        cdll_pkg::CMD_INS_AT: begin
                            if (ins_pos == '0 || ins_pos > count_p + POS_W'(1)) begin
                                n_out.status = cdll_pkg::STAT_INVALID;
                            end else if (r_count == CNT_W'(CAPACITY)) begin
                                n_out.status = cdll_pkg::STAT_FULL;
                            end else begin
                                cell_ctrl.op      = cdll_pkg::CELL_INSERT;
                                cell_ctrl.pos_idx = ins_pos - POS_W'(1);
                                n_count           = r_count + CNT_W'(1);
                            end
                        end
                        cdll_pkg::CMD_DEL_FRONT,
                        cdll_pkg::CMD_DEL_BACK,
                        cdll_pkg::CMD_DEL_AT: begin
                            if (r_count == '0) begin
                                n_out.status = cdll_pkg::STAT_EMPTY;
                            end else if (del_pos == '0 || del_pos > count_p) begin
                                n_out.status = cdll_pkg::STAT_INVALID;
                            end else begin
                                cell_ctrl.op      = cdll_pkg::CELL_DELETE;
                                cell_ctrl.pos_idx = del_pos - POS_W'(1);
                                n_count           = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_out.status = cdll_pkg::STAT_EMPTY;
                            end else begin
                                // results come from the ring walk instead
                                n_out_valid = r_out_valid && !i_out_ready;
                                n_out       = r_out;
                                show_start  = 1'b1;
                                n_step      = '0;
                                n_emit      = '0;
                                n_dir_back  = (i_in.command == cdll_pkg::CMD_SHOW_BACK);
                            end
                        end
                    endcase
                end
            end
            cdll_pkg::ST_SHOW: begin
                emit     = tap.valid && (POS_W'(r_emit) < limit);
                step_adv = !emit || out_free;
                if (step_adv) begin
                    cell_ctrl.op = r_dir_back ? cdll_pkg::CELL_ROT_RIGHT
                                              : cdll_pkg::CELL_ROT_LEFT;
                    n_step       = r_step + STEP_W'(1);
                    if (emit) begin
                        n_out.element = tap.value;
                        n_out.status  = cdll_pkg::STAT_OK;
                        n_out.last    = (POS_W'(r_emit) + POS_W'(1) == limit);
                        n_out_valid   = 1'b1;
                        n_emit        = r_emit + EMIT_W'(1);
                    end
                end
            end
            default: ;
        endcase
    end

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            cdll_pkg::ST_IDLE: begin
                if (show_start) begin
                    n_state = cdll_pkg::ST_SHOW;
                end
            end
            cdll_pkg::ST_SHOW: begin
                if (step_adv && last_step) begin
                    n_state = cdll_pkg::ST_IDLE;
                end
            end
            default: n_state = cdll_pkg::ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cdll_pkg::ST_IDLE;
            r_count     <= '0;
            r_step      <= '0;
            r_emit      <= '0;
            r_dir_back  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_step      <= n_step;
            r_emit      <= n_emit;
            r_dir_back  <= n_dir_back;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_chain_packed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdll_pkg::ST_IDLE) |->
            ((cell_q[0].valid == (r_count != '0)) &&
             (cell_q[CAPACITY-1].valid == (r_count == CNT_W'(CAPACITY)))))
        else $error("occupied cells do not match element count");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(o_out) && o_out_valid))
        else $error("held result overwritten");

    a_show_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cdll_pkg::ST_SHOW && n_state == cdll_pkg::ST_IDLE) |->
            (POS_W'(r_emit) + POS_W'(emit) == limit))
        else $error("show ended without reporting every element");

endmodule

// ===== verif/circular_doubly_linked_list_tb.sv =====
// Testbench for the circular doubly linked list: scoreboard, stimulus and result checking.
`timescale 1ns / 1ps

module circular_doubly_linked_list_tb;

    localparam int CAPACITY    = 32;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_ITEMS = 64;

    // Ordered copy of the list plus the queue of results still owed by the block.
    // The block holds its elements in cell order, so order alone is kept here.
    class list_scoreboard;
        logic signed [cdll_pkg::VALUE_W-1:0] contents[$];
        cdll_pkg::t_out_item                 owed_results[$];
        int                                  capacity;
        int                                  errors;

        function new(int cap);
            capacity = cap;
            errors   = 0;
        endfunction

        function int count();
            return contents.size();
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        task report(input string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function void add_owed(logic signed [cdll_pkg::VALUE_W-1:0] elem,
                               cdll_pkg::t_status st, logic lst);
            cdll_pkg::t_out_item r;
            r.element = elem;
            r.status  = st;
            r.last    = lst;
            owed_results.push_back(r);
        endfunction

        // Apply one accepted command to the list and queue what it must produce.
        function void note_command(cdll_pkg::t_in_item item);
            int                n;
            int                pos;
            int                emit;
            cdll_pkg::t_status st;
            n = contents.size();
            case (item.command)
                cdll_pkg::CMD_INS_FRONT, cdll_pkg::CMD_INS_BACK, cdll_pkg::CMD_INS_AT: begin
                    if (item.command == cdll_pkg::CMD_INS_FRONT)
                        pos = 1;
                    else if (item.command == cdll_pkg::CMD_INS_BACK)
                        pos = n + 1;
                    else
                        pos = int'(item.position);
                    if (pos < 1 || pos > n + 1) begin
                        st = cdll_pkg::STAT_INVALID;
                    end else if (n >= capacity) begin
                        st = cdll_pkg::STAT_FULL;
                    end else begin
                        if (pos == n + 1)
                            contents.push_back(item.value);
                        else
                            contents.insert(pos - 1, item.value);
                        st = cdll_pkg::STAT_OK;
                    end
                    add_owed('0, st, 1'b1);
                end
                cdll_pkg::CMD_DEL_FRONT, cdll_pkg::CMD_DEL_BACK, cdll_pkg::CMD_DEL_AT: begin
                    if (item.command == cdll_pkg::CMD_DEL_FRONT)
                        pos = 1;
                    else if (item.command == cdll_pkg::CMD_DEL_BACK)
                        pos = n;
                    else
                        pos = int'(item.position);
                    if (n == 0) begin
                        st = cdll_pkg::STAT_EMPTY;
                    end else if (pos < 1 || pos > n) begin
                        st = cdll_pkg::STAT_INVALID;
                    end else begin
                        contents.delete(pos - 1);
                        st = cdll_pkg::STAT_OK;
                    end
                    add_owed('0, st, 1'b1);
                end
                default: begin
                    if (n == 0) begin
                        add_owed('0, cdll_pkg::STAT_EMPTY, 1'b1);
                    end else begin
                        emit = (n < cdll_pkg::MAX_RESULTS) ? n : cdll_pkg::MAX_RESULTS;
                        for (int i = 0; i < emit; i++) begin
                            if (item.command == cdll_pkg::CMD_SHOW_FWD)
                                add_owed(contents[i], cdll_pkg::STAT_OK, i == emit - 1);
                            else
                                add_owed(contents[n - 1 - i], cdll_pkg::STAT_OK,
                                         i == emit - 1);
                        end
                    end
                end
            endcase
        endfunction

        task check_result(input cdll_pkg::t_out_item got);
            cdll_pkg::t_out_item want;
            if (owed_results.size() == 0) begin
                report($sformatf("unexpected result element=%0d status=%0d last=%0b",
                                 got.element, got.status, got.last));
                return;
            end
            want = owed_results.pop_front();
            if (got.element !== want.element)
                report($sformatf("element got %0d want %0d", got.element, want.element));
            if (got.status !== want.status)
                report($sformatf("status got %0d want %0d", got.status, want.status));
            if (got.last !== want.last)
                report($sformatf("last got %0b want %0b", got.last, want.last));
        endtask
    endclass

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                cmd_valid = 1'b0;
    logic                cmd_ready;
    cdll_pkg::t_in_item  cmd_item  = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    cdll_pkg::t_out_item res_item;

    // Percentages of cycles in which the sender holds back or the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    list_scoreboard sb = new(CAPACITY);

    // Values that sit on the edges of the signed range.
    logic signed [cdll_pkg::VALUE_W-1:0] edge_values[4] =
        '{32'sh8000_0000, 32'sh7FFF_FFFF, '0, -32'sd1};
    cdll_pkg::t_cmd ins_cmds[3] =
        '{cdll_pkg::CMD_INS_FRONT, cdll_pkg::CMD_INS_BACK, cdll_pkg::CMD_INS_AT};
    cdll_pkg::t_cmd del_cmds[3] =
        '{cdll_pkg::CMD_DEL_FRONT, cdll_pkg::CMD_DEL_BACK, cdll_pkg::CMD_DEL_AT};

    circular_doubly_linked_list #(
        .CAPACITY (CAPACITY)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (cmd_valid),
        .o_in_ready  (cmd_ready),
        .i_in        (cmd_item),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out       (res_item)
    );

    always #2 clk = ~clk;

    // Result side: ready is re-rolled every cycle, so stalls land on every phase of a show.
    always @(posedge clk) begin
        res_ready <= ($urandom_range(99, 0) >= stall_pct);
    end

    // Result monitor: a transfer happens at an edge with valid and ready both high.
    // Values read here are those from before the edge, so no race with the drivers.
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_item);
    end

    // Watchdog: bounds the run well above the slowest legal case.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL circular_doubly_linked_list");
            $finish;
        end
    end

    // Drive one command and hold it until the transfer. Valid stays high between
    // back-to-back commands; it only drops when the sender decides to idle first.
    task automatic send_command(input cdll_pkg::t_cmd c,
                                input logic signed [cdll_pkg::VALUE_W-1:0] v,
                                input logic [cdll_pkg::POS_W-1:0] p);
        cdll_pkg::t_in_item item;
        item.command  = c;
        item.value    = v;
        item.position = p;
        if ($urandom_range(99, 0) < idle_pct) begin
            cmd_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99, 0) < idle_pct);
        end
        cmd_valid <= 1'b1;
        cmd_item  <= item;
        do @(posedge clk); while (!cmd_ready);
        // Noted here rather than in a monitor so stimulus choices see a settled count.
        sb.note_command(item);
    endtask

    // Random traffic in bursts: growing bursts push the list to full, shrinking ones
    // drain it to empty, mixed ones wander. Most positions are in range so the shift
    // logic of the cells is exercised; the rest sweep the whole position field.
    task automatic run_random(input int items);
        int                                  mode;
        int                                  burst;
        int                                  roll;
        int                                  ins_share;
        int                                  n;
        cdll_pkg::t_cmd                      c;
        logic signed [cdll_pkg::VALUE_W-1:0] v;
        logic [cdll_pkg::POS_W-1:0]          p;
        while (items > 0) begin
            mode  = $urandom_range(2, 0);
            burst = $urandom_range(40, 10);
            ins_share = (mode == 0) ? 72 : (mode == 1) ? 22 : 46;
            while (burst > 0 && items > 0) begin
                n    = sb.count();
                roll = $urandom_range(99, 0);
                if (roll < 8)
                    c = ($urandom_range(1, 0) != 0) ? cdll_pkg::CMD_SHOW_FWD
                                                    : cdll_pkg::CMD_SHOW_BACK;
                else if (roll < 8 + ins_share)
                    c = ins_cmds[$urandom_range(2, 0)];
                else
                    c = del_cmds[$urandom_range(2, 0)];

                if ($urandom_range(99, 0) < 10)
                    v = edge_values[$urandom_range(3, 0)];
                else
                    v = $urandom;

                roll = $urandom_range(99, 0);
                if (c == cdll_pkg::CMD_INS_AT && roll < 80)
                    p = cdll_pkg::POS_W'($urandom_range(n + 1, 1));
                else if (c == cdll_pkg::CMD_DEL_AT && n > 0 && roll < 80)
                    p = cdll_pkg::POS_W'($urandom_range(n, 1));
                else
                    p = cdll_pkg::POS_W'($urandom_range(255, 0));

                send_command(c, v, p);
                burst--;
                items--;
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, no idling: empty list, bad positions, edge values, both shows.
        send_command(cdll_pkg::CMD_SHOW_FWD,  '0, '0);
        send_command(cdll_pkg::CMD_SHOW_BACK, '0, '0);
        send_command(cdll_pkg::CMD_DEL_FRONT, '0, '0);
        send_command(cdll_pkg::CMD_DEL_BACK,  '0, '0);
        send_command(cdll_pkg::CMD_DEL_AT,    '0, 8'd0);
        send_command(cdll_pkg::CMD_DEL_AT,    '0, 8'd255);
        send_command(cdll_pkg::CMD_INS_AT,    32'sd7, 8'd0);
        send_command(cdll_pkg::CMD_INS_AT,    32'sd7, 8'd2);
        send_command(cdll_pkg::CMD_INS_AT,    32'sh7FFF_FFFF, 8'd1);
        send_command(cdll_pkg::CMD_INS_FRONT, 32'sh8000_0000, '0);
        send_command(cdll_pkg::CMD_INS_BACK,  -32'sd1, '0);
        send_command(cdll_pkg::CMD_INS_AT,    '0, 8'd4);
        send_command(cdll_pkg::CMD_INS_AT,    32'sh5555_5555, 8'd2);
        send_command(cdll_pkg::CMD_INS_AT,    32'sh2AAA_AAAA, 8'd255);
        send_command(cdll_pkg::CMD_SHOW_FWD,  '0, '0);
        send_command(cdll_pkg::CMD_SHOW_BACK, '0, '0);
        send_command(cdll_pkg::CMD_DEL_AT,    '0, 8'd6);
        send_command(cdll_pkg::CMD_DEL_AT,    '0, 8'd0);
        send_command(cdll_pkg::CMD_DEL_AT,    '0, 8'd3);
        send_command(cdll_pkg::CMD_DEL_FRONT, '0, '0);
        send_command(cdll_pkg::CMD_DEL_BACK,  '0, '0);
        send_command(cdll_pkg::CMD_DEL_AT,    '0, 8'd2);
        send_command(cdll_pkg::CMD_DEL_AT,    '0, 8'd1);
        send_command(cdll_pkg::CMD_SHOW_BACK, '0, '0);

        // Random phases with different pressure on each side.
        run_random(PHASE_ITEMS);
        idle_pct  = 63;
        run_random(PHASE_ITEMS);
        idle_pct  = 0;
        stall_pct = 63;
        run_random(PHASE_ITEMS);
        idle_pct  = 31;
        stall_pct = 31;
        run_random(PHASE_ITEMS);

        cmd_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        // Wait out a full turn of the ring by a show so that stray results still show up.
        repeat (CAPACITY + 8) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS circular_doubly_linked_list");
        end else begin
            $display("FAIL circular_doubly_linked_list");
        end
        $finish;
    end

endmodule
